@@ src/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, command codes and calendar helpers for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam logic [2:0] CMD_LOAD       = 3'd0;
	localparam logic [2:0] CMD_NEXT_DAY   = 3'd1;
	localparam logic [2:0] CMD_PREV_DAY   = 3'd2;
	localparam logic [2:0] CMD_NEXT_MONTH = 3'd3;
	localparam logic [2:0] CMD_PREV_MONTH = 3'd4;
	localparam logic [2:0] CMD_NEXT_YEAR  = 3'd5;
	localparam logic [2:0] CMD_PREV_YEAR  = 3'd6;

	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [6:0]  PART_MAX   = 7'd99;
	localparam logic [3:0]  MONTH_MAX  = 4'd12;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_APR  = 4'd4;
	localparam logic [3:0]  MONTH_JUN  = 4'd6;
	localparam logic [3:0]  MONTH_SEP  = 4'd9;
	localparam logic [3:0]  MONTH_NOV  = 4'd11;
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [4:0]  RST_DAY   = 5'd1;
	localparam logic [3:0]  RST_MONTH = 4'd1;
	localparam logic [13:0] RST_YEAR  = 14'd2000;
	localparam logic [6:0]  RST_CENT  = 7'd20;
	localparam logic [6:0]  RST_YY    = 7'd0;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  load_day;
		logic [3:0]  load_month;
		logic [13:0] load_year;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [13:0] year_out;
		logic        leap_out;
	} date_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  load_day;
		logic [3:0]  load_month;
		logic [13:0] load_year;
		logic [6:0]  load_cent;
	} item_t;

	// year given as century and year within century
	function automatic logic leap_of(input logic [6:0] cent, input logic [6:0] yy);
		logic lp;
		lp = (yy == 7'd0) ? (cent[1:0] == 2'b00) : (yy[1:0] == 2'b00);
		return lp;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ src/cds_in_stage.sv @@
// ----------------------------------------------------------------------------
// cds_in_stage
// Input register: clamps load month and year, splits the load year by 100.
// ----------------------------------------------------------------------------
module cds_in_stage import cds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	input  logic  take,
	output logic  vld_s1,
	output item_t item_s1
);

	logic [3:0]  lm_c;
	logic [13:0] ly_c;
	logic [26:0] prod;

	assign lm_c = (cmd.load_month == 4'd0) ? 4'd1 :
		(cmd.load_month > MONTH_MAX) ? MONTH_MAX : cmd.load_month;
	assign ly_c = (cmd.load_year > YEAR_MAX) ? YEAR_MAX : cmd.load_year;
	// quotient by 100 through a reciprocal, exact below 16384
	assign prod = 27'(ly_c) * 27'(RECIP_100);

	assign cmd_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_valid && cmd_ready) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1.command    <= cmd.command;
			item_s1.load_day   <= cmd.load_day;
			item_s1.load_month <= lm_c;
			item_s1.load_year  <= ly_c;
			item_s1.load_cent  <= prod[RECIP_SHIFT+6:RECIP_SHIFT];
		end
	end

endmodule

@@ src/cds_date_core.sv @@
// ----------------------------------------------------------------------------
// cds_date_core
// Date registers and the next-date logic for one command.
// ----------------------------------------------------------------------------
module cds_date_core import cds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item_s1,
	output date_t nxt
);

	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic [6:0]  cent_q;
	logic [6:0]  yy_q;

	logic [13:0] lq_x100;
	logic [13:0] lrem_w;
	logic [6:0]  lrem;
	logic        leap_ld;
	logic [4:0]  len_ld;

	logic [6:0]  yy_inc, yy_dec, cent_inc, cent_dec;
	logic [13:0] year_inc, year_dec;
	logic        leap_cur, leap_inc, leap_dec;
	logic [3:0]  m_inc, m_dec;
	logic [4:0]  len_cur, len_minc, len_mdec, len_dec12, len_yinc, len_ydec;

	logic [4:0]  d_n;
	logic [3:0]  m_n;
	logic [13:0] y_n;
	logic [6:0]  c_n, yy_n;

	// remainder of the load year by 100
	assign lq_x100 = (14'(item_s1.load_cent) << 6) + (14'(item_s1.load_cent) << 5)
		+ (14'(item_s1.load_cent) << 2);
	assign lrem_w  = item_s1.load_year - lq_x100;
	assign lrem    = lrem_w[6:0];
	assign leap_ld = leap_of(item_s1.load_cent, lrem);
	assign len_ld  = month_len(item_s1.load_month, leap_ld);

	assign yy_inc   = (yy_q == PART_MAX) ? 7'd0 : yy_q + 7'd1;
	assign cent_inc = (yy_q != PART_MAX) ? cent_q :
		(cent_q == PART_MAX) ? 7'd0 : cent_q + 7'd1;
	assign yy_dec   = (yy_q == 7'd0) ? PART_MAX : yy_q - 7'd1;
	assign cent_dec = (yy_q != 7'd0) ? cent_q :
		(cent_q == 7'd0) ? PART_MAX : cent_q - 7'd1;
	assign year_inc = (year_q >= YEAR_MAX) ? 14'd0 : year_q + 14'd1;
	assign year_dec = (year_q == 14'd0) ? YEAR_MAX : year_q - 14'd1;

	assign leap_cur = leap_of(cent_q, yy_q);
	assign leap_inc = leap_of(cent_inc, yy_inc);
	assign leap_dec = leap_of(cent_dec, yy_dec);

	assign m_inc = (month_q >= MONTH_MAX) ? 4'd1 : month_q + 4'd1;
	assign m_dec = (month_q <= 4'd1) ? MONTH_MAX : month_q - 4'd1;

	assign len_cur   = month_len(month_q, leap_cur);
	assign len_minc  = month_len(m_inc, leap_cur);
	assign len_mdec  = month_len(m_dec, leap_cur);
	assign len_dec12 = month_len(MONTH_MAX, leap_dec);
	assign len_yinc  = month_len(month_q, leap_inc);
	assign len_ydec  = month_len(month_q, leap_dec);

	always_comb begin
		d_n  = day_q;
		m_n  = month_q;
		y_n  = year_q;
		c_n  = cent_q;
		yy_n = yy_q;
		case (item_s1.command)
			CMD_LOAD: begin
				m_n  = item_s1.load_month;
				y_n  = item_s1.load_year;
				c_n  = item_s1.load_cent;
				yy_n = lrem;
				d_n  = (item_s1.load_day == 5'd0) ? 5'd1 :
					(item_s1.load_day > len_ld) ? len_ld : item_s1.load_day;
			end
			CMD_NEXT_DAY: begin
				if (day_q < len_cur) begin
					d_n = day_q + 5'd1;
				end else begin
					d_n = 5'd1;
					m_n = m_inc;
					if (month_q >= MONTH_MAX) begin
						y_n  = year_inc;
						c_n  = cent_inc;
						yy_n = yy_inc;
					end
				end
			end
			CMD_PREV_DAY: begin
				if (day_q > 5'd1) begin
					d_n = day_q - 5'd1;
				end else if (month_q <= 4'd1) begin
					m_n  = MONTH_MAX;
					y_n  = year_dec;
					c_n  = cent_dec;
					yy_n = yy_dec;
					d_n  = len_dec12;
				end else begin
					m_n = m_dec;
					d_n = len_mdec;
				end
			end
			CMD_NEXT_MONTH: begin
				m_n = m_inc;
				d_n = (day_q > len_minc) ? len_minc : day_q;
			end
			CMD_PREV_MONTH: begin
				m_n = m_dec;
				d_n = (day_q > len_mdec) ? len_mdec : day_q;
			end
			CMD_NEXT_YEAR: begin
				y_n  = year_inc;
				c_n  = cent_inc;
				yy_n = yy_inc;
				d_n  = (day_q > len_yinc) ? len_yinc : day_q;
			end
			CMD_PREV_YEAR: begin
				y_n  = year_dec;
				c_n  = cent_dec;
				yy_n = yy_dec;
				d_n  = (day_q > len_ydec) ? len_ydec : day_q;
			end
			default: begin
				d_n = day_q;
			end
		endcase
	end

	assign nxt.day_out   = d_n;
	assign nxt.month_out = m_n;
	assign nxt.year_out  = y_n;
	assign nxt.leap_out  = leap_of(c_n, yy_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= RST_DAY;
			month_q <= RST_MONTH;
			year_q  <= RST_YEAR;
			cent_q  <= RST_CENT;
			yy_q    <= RST_YY;
		end else if (step) begin
			day_q   <= d_n;
			month_q <= m_n;
			year_q  <= y_n;
			cent_q  <= c_n;
			yy_q    <= yy_n;
		end
	end

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		day_q != 5'd0 && day_q <= month_len(month_q, leap_of(cent_q, yy_q)))
		else $error("day outside month length");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		month_q >= 4'd1 && month_q <= MONTH_MAX)
		else $error("month out of range");

	a_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		year_q == (14'(cent_q) * 14'd100) + 14'(yy_q) && yy_q <= PART_MAX)
		else $error("century split disagrees with year");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(year_q) && $stable(month_q) && $stable(day_q))
		else $error("date changed without a command");

endmodule

@@ src/calendar_date_stepper.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date counter driven by load and step commands.
// ----------------------------------------------------------------------------
// Takes one command per clock cycle while the date output is not stalled and
// returns one date per command. Each command passes through the input
// register, then the result register, before its date is offered. The date
// registers update on each accepted step, so commands may arrive back to back
// with no gap. After reset the date is 2000-01-01.
// Loads clamp month, year and day into range; years wrap between 0 and 9999.
module calendar_date_stepper import cds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	output logic  date_valid,
	input  logic  date_ready,
	output date_t date
);

	logic  vld_s1;
	item_t item_s1;
	logic  adv;
	logic  take;
	date_t nxt;
	logic  vld_s2;
	date_t date_s2;

	assign adv  = !vld_s2 || date_ready;
	assign take = vld_s1 && adv;

	cds_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.take      (take),
		.vld_s1    (vld_s1),
		.item_s1   (item_s1)
	);

	cds_date_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.item_s1 (item_s1),
		.nxt     (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			date_s2 <= nxt;
		end
	end

	assign date_valid = vld_s2;
	assign date       = date_s2;

endmodule

@@ bench/date_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_checker
// Watches both channels of the date stepper, tracks the calendar date that
// each accepted command should produce, and compares every returned date
// against the oldest date still due. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module date_checker import cds_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  logic  cmd_ready,
	input  cmd_t  cmd,
	input  logic  date_valid,
	input  logic  date_ready,
	input  date_t date,
	output int    failures,
	output int    pending,
	output int    checked
);

	localparam int PRINT_CAP = 40;

	date_t calendar = '{day_out: RST_DAY, month_out: RST_MONTH, year_out: RST_YEAR,
		leap_out: 1'b1};
	date_t due_dates[$];
	int    fail_count = 0;
	int    compared = 0;
	int    queued = 0;

	assign failures = fail_count;
	assign pending  = queued;
	assign checked  = compared;

	function automatic logic is_leap_year(input logic [13:0] y);
		if (y % 400 == 0) return 1'b1;
		if (y % 100 == 0) return 1'b0;
		return (y % 4 == 0);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [13:0] y);
		case (m)
			MONTH_FEB: return is_leap_year(y) ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
			default: return 5'd31;
		endcase
	endfunction

	function automatic logic [13:0] year_after(input logic [13:0] y);
		return (y >= YEAR_MAX) ? 14'd0 : y + 14'd1;
	endfunction

	function automatic logic [13:0] year_before(input logic [13:0] y);
		return (y == 14'd0 || y > YEAR_MAX) ? YEAR_MAX : y - 14'd1;
	endfunction

	// clamping the day after every command fixes loads and month or year steps
	function automatic date_t apply_command(input date_t d, input cmd_t c);
		date_t      n;
		logic [4:0] len;
		n = d;
		case (c.command)
			CMD_LOAD: begin
				n.month_out = c.load_month;
				if (n.month_out < 4'd1) n.month_out = 4'd1;
				if (n.month_out > MONTH_MAX) n.month_out = MONTH_MAX;
				n.year_out = (c.load_year > YEAR_MAX) ? YEAR_MAX : c.load_year;
				n.day_out = c.load_day;
			end
			CMD_NEXT_DAY: begin
				if (n.day_out < days_in_month(n.month_out, n.year_out)) begin
					n.day_out = n.day_out + 5'd1;
				end else begin
					n.day_out = 5'd1;
					if (n.month_out >= MONTH_MAX) begin
						n.month_out = 4'd1;
						n.year_out = year_after(n.year_out);
					end else begin
						n.month_out = n.month_out + 4'd1;
					end
				end
			end
			CMD_PREV_DAY: begin
				if (n.day_out > 5'd1) begin
					n.day_out = n.day_out - 5'd1;
				end else begin
					if (n.month_out <= 4'd1) begin
						n.month_out = MONTH_MAX;
						n.year_out = year_before(n.year_out);
					end else begin
						n.month_out = n.month_out - 4'd1;
					end
					n.day_out = days_in_month(n.month_out, n.year_out);
				end
			end
			CMD_NEXT_MONTH: n.month_out = (n.month_out >= MONTH_MAX) ? 4'd1 : n.month_out + 4'd1;
			CMD_PREV_MONTH: n.month_out = (n.month_out <= 4'd1) ? MONTH_MAX : n.month_out - 4'd1;
			CMD_NEXT_YEAR: n.year_out = year_after(n.year_out);
			CMD_PREV_YEAR: n.year_out = year_before(n.year_out);
			default: ;
		endcase
		len = days_in_month(n.month_out, n.year_out);
		if (n.day_out > len) n.day_out = len;
		if (n.day_out < 5'd1) n.day_out = 5'd1;
		n.leap_out = is_leap_year(n.year_out);
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP) $display("@%0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : watch
		date_t want;
		string wrong;
		if (arst_n) begin
			if (date_valid && date_ready) begin
				if (due_dates.size() == 0) begin
					report_mismatch($sformatf("date %0d-%0d-%0d leap %0b with none due",
						date.year_out, date.month_out, date.day_out, date.leap_out));
				end else begin
					want = due_dates.pop_front();
					compared++;
					wrong = "";
					if (date.day_out !== want.day_out)
						wrong = {wrong, $sformatf(" day %0d/%0d", date.day_out, want.day_out)};
					if (date.month_out !== want.month_out)
						wrong = {wrong, $sformatf(" month %0d/%0d", date.month_out, want.month_out)};
					if (date.year_out !== want.year_out)
						wrong = {wrong, $sformatf(" year %0d/%0d", date.year_out, want.year_out)};
					if (date.leap_out !== want.leap_out)
						wrong = {wrong, $sformatf(" leap %0b/%0b", date.leap_out, want.leap_out)};
					if (wrong != "") report_mismatch({"date transfer, got/want:", wrong});
				end
			end
			if (cmd_valid && cmd_ready) begin
				calendar = apply_command(calendar, cmd);
				due_dates.push_back(calendar);
			end
			queued = due_dates.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the date stepper with directed calendar corner cases and then a
// long random command stream with random idling on both channels, a long
// result stall and a full drain mid-run; the checker judges every date.
// ----------------------------------------------------------------------------
module testbench;
	import cds_pkg::*;

	localparam logic [2:0] CMD_HOLD = 3'd7;
	localparam int ITEM_COUNT   = 850;
	localparam int HOLD_AT      = 200;
	localparam int PAUSE_AT     = 450;
	localparam int QUIET_FROM   = 700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic  clk;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_ready;
	cmd_t  cmd;
	logic  date_valid;
	logic  date_ready;
	date_t date;

	int failures;
	int pending;
	int checked;
	int cycle_count = 0;
	int sent_by_cmd[8];
	bit hold_req = 1'b0;
	bit quiet = 1'b0;

	calendar_date_stepper DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date       (date)
	);

	date_checker CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date       (date),
		.failures   (failures),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("calendar_date_stepper: mismatch");
		$finish;
	end

	function automatic cmd_t make_cmd(input logic [2:0] op, input logic [4:0] d,
		input logic [3:0] m, input logic [13:0] y);
		cmd_t c;
		c.command    = op;
		c.load_day   = d;
		c.load_month = m;
		c.load_year  = y;
		return c;
	endfunction

	function automatic cmd_t noise();
		return make_cmd(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
			4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)));
	endfunction

	// loads biased toward month ends, february and awkward years
	function automatic cmd_t edge_load();
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		case ($urandom_range(0, 7))
			0: y = 14'd0;
			1: y = YEAR_MAX;
			2: y = 14'(100 * $urandom_range(0, 99));
			3: y = 14'(400 * $urandom_range(0, 24));
			4: y = 14'(4 * $urandom_range(0, 2499));
			5: y = 14'($urandom_range(9990, 9999));
			default: y = 14'($urandom_range(0, 9999));
		endcase
		case ($urandom_range(0, 3))
			0: m = 4'd1;
			1: m = MONTH_FEB;
			2: m = MONTH_MAX;
			default: m = 4'($urandom_range(1, 12));
		endcase
		d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31)) :
			5'($urandom_range(27, 31));
		return make_cmd(CMD_LOAD, d, m, y);
	endfunction

	task automatic send(input cmd_t c);
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sent_by_cmd[c.command]++;
	endtask

	task automatic pace();
		if (!quiet && !hold_req && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			cmd <= noise();
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic wait_all_dates();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		date_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				date_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				date_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				date_ready <= 1'b1;
				repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20)) @(posedge clk);
			end else begin
				date_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	end

	initial begin
		cmd_t       plan[$];
		cmd_t       c;
		logic [2:0] run_op;
		int         pick;

		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(make_cmd(CMD_PREV_DAY, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_NEXT_DAY, 5'd31, 4'd15, 14'd16383));
		plan.push_back(make_cmd(CMD_LOAD, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_PREV_DAY, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_NEXT_DAY, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_PREV_YEAR, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_NEXT_YEAR, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_LOAD, 5'd31, 4'd15, 14'd16383));
		plan.push_back(make_cmd(CMD_NEXT_DAY, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_LOAD, 5'd31, MONTH_FEB, 14'd2000));
		plan.push_back(make_cmd(CMD_NEXT_YEAR, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_LOAD, 5'd29, MONTH_FEB, 14'd1900));
		plan.push_back(make_cmd(CMD_LOAD, 5'd31, MONTH_APR, 14'd2024));
		plan.push_back(make_cmd(CMD_LOAD, 5'd29, MONTH_FEB, 14'd2024));
		plan.push_back(make_cmd(CMD_PREV_YEAR, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_LOAD, 5'd29, MONTH_FEB, 14'd0));
		plan.push_back(make_cmd(CMD_LOAD, 5'd31, 4'd1, 14'd2023));
		plan.push_back(make_cmd(CMD_NEXT_MONTH, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_PREV_MONTH, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_LOAD, 5'd15, MONTH_MAX, 14'd2023));
		plan.push_back(make_cmd(CMD_NEXT_MONTH, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_PREV_MONTH, 5'd0, 4'd0, 14'd0));
		plan.push_back(make_cmd(CMD_HOLD, 5'd31, 4'd15, 14'd16383));
		plan.push_back(make_cmd(CMD_LOAD, 5'd28, MONTH_FEB, 14'd2100));
		plan.push_back(make_cmd(CMD_NEXT_DAY, 5'd0, 4'd0, 14'd0));
		foreach (plan[k]) begin
			send(plan[k]);
			pace();
		end

		run_op = CMD_NEXT_DAY;
		for (int i = 0; i < ITEM_COUNT; i++) begin
			if (i == HOLD_AT) hold_req = 1'b1;
			if (i == PAUSE_AT) wait_all_dates();
			if (i == QUIET_FROM) quiet = 1'b1;
			pick = $urandom_range(0, 15);
			if (pick < 2) begin
				c = edge_load();
			end else if (pick == 2) begin
				c = noise();
			end else begin
				if ($urandom_range(0, 2) == 0)
					run_op = 3'($urandom_range(CMD_NEXT_DAY, CMD_PREV_YEAR));
				c = noise();
				c.command = run_op;
			end
			send(c);
			pace();
		end

		wait_all_dates();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("covered %0d commands: %0d loads, %0d day, %0d month, %0d year steps, %0d unused",
			sent_by_cmd.sum(), sent_by_cmd[CMD_LOAD],
			sent_by_cmd[CMD_NEXT_DAY] + sent_by_cmd[CMD_PREV_DAY],
			sent_by_cmd[CMD_NEXT_MONTH] + sent_by_cmd[CMD_PREV_MONTH],
			sent_by_cmd[CMD_NEXT_YEAR] + sent_by_cmd[CMD_PREV_YEAR], sent_by_cmd[CMD_HOLD]);
		$display("%0d dates compared across random stalls, a long output hold-off and a full drain",
			checked);
		if (failures == 0) begin
			$display("calendar_date_stepper: match");
		end else begin
			$display("calendar_date_stepper: mismatch");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/cds_pkg.sv
src/cds_in_stage.sv
src/cds_date_core.sv
src/calendar_date_stepper.sv
bench/date_checker.sv
bench/testbench.sv
